>>> sv/lbc_pkg.sv
package lbc_pkg;

    localparam int TIME_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int IN_DATA_BITS   = 56;
    localparam int IN_USER_BITS   = 2;
    localparam int OUT_DATA_BITS  = 24;
    localparam int FIELD_BITS     = 16;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SET    = 2'd1,
        CMD_TOGGLE = 2'd2,
        CMD_START  = 2'd3
    } t_cmd;

    typedef enum logic {
        STS_OK       = 1'b0,
        STS_REJECTED = 1'b1
    } t_status;

endpackage

>>> sv/led_blink_controller.sv
// Channel   | Dir | Handshake              | Payload
// ----------+-----+------------------------+-----------------------------------------
// command   | in  | i_s_tvalid/o_s_tready  | tuser: cmd; tdata: level, on, off, total
// result    | out | o_m_tvalid/i_m_tready  | tdata: led_level, blinking, done, status
//
// One request per clock while o_s_tready is high; each result is registered.
// State updates in the accepting cycle, so back-to-back requests chain directly.
// A result register plus one skid entry let the input take a request during output stall.
// Synchronous active-low reset: LED dark, no blinking, counters zero, buffers empty.
module led_blink_controller
    import lbc_pkg::*;
#(
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // [0] level, [16:1] on_time, [32:17] off_time, [48:33] repeat_total, [55:49] zero
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,
    // [1:0] cmd
    input  logic [IN_USER_BITS-1:0]  i_s_tuser,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // [0] led_level, [1] blinking, [17:2] blinks_done, [18] status, [23:19] zero
    output logic [OUT_DATA_BITS-1:0] o_m_tdata
);

    typedef struct packed {
        t_status               status;
        logic [FIELD_BITS-1:0] blinks_done;
        logic                  blinking;
        logic                  led_level;
    } t_result;

    localparam int RES_BITS = $bits(t_result);

    logic                  r_led;
    logic                  r_running;
    logic                  r_lit_phase;
    logic [COUNT_BITS-1:0] r_counter;
    logic [TIME_BITS-1:0]  r_ticks_left;
    logic [TIME_BITS-1:0]  r_lit_ticks;
    logic [TIME_BITS-1:0]  r_dark_ticks;
    logic [COUNT_BITS-1:0] r_target;

    logic                  n_led;
    logic                  n_running;
    logic                  n_lit_phase;
    logic [COUNT_BITS-1:0] n_counter;
    logic [TIME_BITS-1:0]  n_ticks_left;
    logic [TIME_BITS-1:0]  n_lit_ticks;
    logic [TIME_BITS-1:0]  n_dark_ticks;
    logic [COUNT_BITS-1:0] n_target;
    t_status               n_status;

    logic                  r_out_valid;
    t_result               r_out;
    logic                  r_sk_valid;
    t_result               r_sk;
    t_result               n_res;

    t_cmd                  cmd;
    logic                  level;
    logic [TIME_BITS-1:0]  on_t;
    logic [TIME_BITS-1:0]  off_t;
    logic [COUNT_BITS-1:0] total;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  accept;
    logic                  out_free;

    assign cmd     = t_cmd'(i_s_tuser[1:0]);
    assign level   = i_s_tdata[0];
    assign on_t    = TIME_BITS'(i_s_tdata[16:1]);
    assign off_t   = TIME_BITS'(i_s_tdata[32:17]);
    assign total   = COUNT_BITS'(i_s_tdata[48:33]);
    assign cnt_inc = r_counter + COUNT_BITS'(1);

    assign o_s_tready = !r_sk_valid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    always_comb begin
        n_led        = r_led;
        n_running    = r_running;
        n_lit_phase  = r_lit_phase;
        n_counter    = r_counter;
        n_ticks_left = r_ticks_left;
        n_lit_ticks  = r_lit_ticks;
        n_dark_ticks = r_dark_ticks;
        n_target     = r_target;
        n_status     = STS_OK;
        case (cmd)
            CMD_TICK: begin
                if (r_running) begin
                    if (r_ticks_left <= TIME_BITS'(1)) begin
                        if (r_lit_phase) begin
                            n_led       = 1'b0;
                            n_lit_phase = 1'b0;
                            n_counter   = cnt_inc;
                            if (r_target != '0 && cnt_inc >= r_target) begin
                                n_running    = 1'b0;
                                n_ticks_left = '0;
                            end else begin
                                n_ticks_left = r_dark_ticks;
                            end
                        end else begin
                            n_led        = 1'b1;
                            n_lit_phase  = 1'b1;
                            n_ticks_left = r_lit_ticks;
                        end
                    end else begin
                        n_ticks_left = r_ticks_left - TIME_BITS'(1);
                    end
                end
            end
            CMD_SET: begin
                n_led = level;
            end
            CMD_TOGGLE: begin
                n_led = !r_led;
            end
            CMD_START: begin
                if (on_t == '0 || off_t == '0) begin
                    n_status = STS_REJECTED;
                end else begin
                    n_lit_ticks  = on_t;
                    n_dark_ticks = off_t;
                    n_target     = total;
                    n_counter    = '0;
                    n_running    = 1'b1;
                    n_led        = 1'b1;
                    n_lit_phase  = 1'b1;
                    n_ticks_left = on_t;
                end
            end
            default: begin
                n_status = STS_OK;
            end
        endcase
        n_res.status      = n_status;
        n_res.blinks_done = FIELD_BITS'(n_counter);
        n_res.blinking    = n_running;
        n_res.led_level   = n_led;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led        <= 1'b0;
            r_running    <= 1'b0;
            r_lit_phase  <= 1'b0;
            r_counter    <= '0;
            r_ticks_left <= '0;
            r_lit_ticks  <= '0;
            r_dark_ticks <= '0;
            r_target     <= '0;
            r_out_valid  <= 1'b0;
            r_sk_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_led        <= n_led;
                r_running    <= n_running;
                r_lit_phase  <= n_lit_phase;
                r_counter    <= n_counter;
                r_ticks_left <= n_ticks_left;
                r_lit_ticks  <= n_lit_ticks;
                r_dark_ticks <= n_dark_ticks;
                r_target     <= n_target;
            end
            if (out_free) begin
                if (r_sk_valid) begin
                    r_out      <= r_sk;
                    r_sk_valid <= 1'b0;
                end else begin
                    r_out_valid <= accept;
                    if (accept) begin
                        r_out <= n_res;
                    end
                end
            end else if (accept) begin
                r_sk       <= n_res;
                r_sk_valid <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_BITS - RES_BITS){1'b0}}, r_out};

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid entry held with empty result register");

    a_phase_times: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_lit_ticks != '0 && r_dark_ticks != '0))
        else $error("blinking with a zero phase time");

    a_ticks_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> r_ticks_left != '0)
        else $error("blinking with no ticks left in phase");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_running && r_target != '0) |-> r_counter < r_target)
        else $error("blink count reached target while still blinking");
`endif

endmodule

>>> tb/tb_led_blink_controller.sv
`timescale 1ns / 100ps

module tb_led_blink_controller;

    import lbc_pkg::*;

    localparam int DIR_ROWS    = 23;
    localparam int RAND_ITEMS  = 1100;
    localparam int BURST_TICKS = 40;

    typedef struct packed {
        t_cmd        cmd;
        logic        level;
        logic [15:0] on_t;
        logic [15:0] off_t;
        logic [15:0] total;
    } t_led_req;

    typedef struct packed {
        logic        led;
        logic        blinking;
        logic [15:0] done;
        t_status     status;
    } t_led_report;

    typedef struct {
        t_led_req    req;
        bit          typed;
        t_led_report want;
    } t_dir_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_s_tvalid;
    logic                     o_s_tready;
    // [0] level, [16:1] on_time, [32:17] off_time, [48:33] repeat_total, [55:49] zero
    logic [IN_DATA_BITS-1:0]  i_s_tdata;
    // [1:0] cmd
    logic [IN_USER_BITS-1:0]  i_s_tuser;
    logic                     o_m_tvalid;
    logic                     i_m_tready;
    // [0] led_level, [1] blinking, [17:2] blinks_done, [18] status, [23:19] zero
    logic [OUT_DATA_BITS-1:0] o_m_tdata;

    // predictor state
    logic        led_q      = 1'b0;
    logic        run_q      = 1'b0;
    logic        lit_q      = 1'b0;
    logic [15:0] done_cnt   = '0;
    logic [15:0] ticks_left = '0;
    logic [15:0] lit_len    = '0;
    logic [15:0] dark_len   = '0;
    logic [15:0] target     = '0;

    t_led_report pending_reports[$];
    bit          idle_on      = 1'b0;
    int          mismatch_cnt = 0;
    int          req_cnt      = 0;
    int          start_cnt    = 0;
    int          reject_cnt   = 0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{'{CMD_TICK,   1'b1, 16'hffff, 16'hffff, 16'hffff}, 1'b1, '{1'b0, 1'b0, 16'd0, STS_OK}},
        '{'{CMD_SET,    1'b1, 16'd0,    16'd0,    16'd0},    1'b1, '{1'b1, 1'b0, 16'd0, STS_OK}},
        '{'{CMD_TOGGLE, 1'b0, 16'd0,    16'd0,    16'd0},    1'b1, '{1'b0, 1'b0, 16'd0, STS_OK}},
        '{'{CMD_TOGGLE, 1'b1, 16'hffff, 16'hffff, 16'hffff}, 1'b1, '{1'b1, 1'b0, 16'd0, STS_OK}},
        '{'{CMD_SET,    1'b0, 16'hffff, 16'hffff, 16'hffff}, 1'b1, '{1'b0, 1'b0, 16'd0, STS_OK}},
        '{'{CMD_START,  1'b0, 16'd0,    16'd5,    16'd1},    1'b1,
          '{1'b0, 1'b0, 16'd0, STS_REJECTED}},
        '{'{CMD_START,  1'b0, 16'd3,    16'd0,    16'd1},    1'b1,
          '{1'b0, 1'b0, 16'd0, STS_REJECTED}},
        '{'{CMD_START,  1'b1, 16'd0,    16'd0,    16'hffff}, 1'b1,
          '{1'b0, 1'b0, 16'd0, STS_REJECTED}},
        '{'{CMD_START,  1'b1, 16'hffff, 16'd0,    16'd0},    1'b1,
          '{1'b0, 1'b0, 16'd0, STS_REJECTED}},
        '{'{CMD_START,  1'b0, 16'd1,    16'd1,    16'd2},    1'b1, '{1'b1, 1'b1, 16'd0, STS_OK}},
        '{'{CMD_TICK,   1'b0, 16'd0,    16'd0,    16'd0},    1'b0, '{1'b0, 1'b0, 16'd0, STS_OK}},
        '{'{CMD_TICK,   1'b1, 16'd0,    16'd0,    16'd0},    1'b0, '{1'b0, 1'b0, 16'd0, STS_OK}},
        '{'{CMD_TOGGLE, 1'b0, 16'd0,    16'd0,    16'd0},    1'b0, '{1'b0, 1'b0, 16'd0, STS_OK}},
        '{'{CMD_TICK,   1'b0, 16'd0,    16'd0,    16'd0},    1'b0, '{1'b0, 1'b0, 16'd0, STS_OK}},
        '{'{CMD_TICK,   1'b0, 16'd0,    16'd0,    16'd0},    1'b0, '{1'b0, 1'b0, 16'd0, STS_OK}},
        '{'{CMD_START,  1'b0, 16'hffff, 16'hffff, 16'd0},    1'b1, '{1'b1, 1'b1, 16'd0, STS_OK}},
        '{'{CMD_SET,    1'b0, 16'd0,    16'd0,    16'd0},    1'b0, '{1'b0, 1'b0, 16'd0, STS_OK}},
        '{'{CMD_TICK,   1'b0, 16'd0,    16'd0,    16'd0},    1'b0, '{1'b0, 1'b0, 16'd0, STS_OK}},
        '{'{CMD_START,  1'b0, 16'd2,    16'd1,    16'd1},    1'b1, '{1'b1, 1'b1, 16'd0, STS_OK}},
        '{'{CMD_TICK,   1'b0, 16'd0,    16'd0,    16'd0},    1'b0, '{1'b0, 1'b0, 16'd0, STS_OK}},
        '{'{CMD_TICK,   1'b0, 16'd0,    16'd0,    16'd0},    1'b0, '{1'b0, 1'b0, 16'd0, STS_OK}},
        '{'{CMD_TICK,   1'b0, 16'd0,    16'd0,    16'd0},    1'b0, '{1'b0, 1'b0, 16'd0, STS_OK}},
        '{'{CMD_START,  1'b0, 16'd1,    16'd1,    16'd0},    1'b1, '{1'b1, 1'b1, 16'd0, STS_OK}}
    };

    led_blink_controller u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_led_report advance_led(t_led_req r);
        t_led_report rep;
        rep.status = STS_OK;
        case (r.cmd)
            CMD_TICK: begin
                if (run_q) begin
                    if (ticks_left <= 16'd1) begin
                        if (lit_q) begin
                            led_q    = 1'b0;
                            lit_q    = 1'b0;
                            done_cnt = done_cnt + 16'd1;
                            if (target != 16'd0 && done_cnt >= target) begin
                                run_q      = 1'b0;
                                ticks_left = '0;
                            end else begin
                                ticks_left = dark_len;
                            end
                        end else begin
                            led_q      = 1'b1;
                            lit_q      = 1'b1;
                            ticks_left = lit_len;
                        end
                    end else begin
                        ticks_left = ticks_left - 16'd1;
                    end
                end
            end
            CMD_SET: led_q = r.level;
            CMD_TOGGLE: led_q = ~led_q;
            default: begin
                if (r.on_t == 16'd0 || r.off_t == 16'd0) begin
                    rep.status = STS_REJECTED;
                end else begin
                    lit_len    = r.on_t;
                    dark_len   = r.off_t;
                    target     = r.total;
                    done_cnt   = '0;
                    run_q      = 1'b1;
                    led_q      = 1'b1;
                    lit_q      = 1'b1;
                    ticks_left = r.on_t;
                end
            end
        endcase
        rep.led      = led_q;
        rep.blinking = run_q;
        rep.done     = done_cnt;
        return rep;
    endfunction

    task automatic send_req(input t_led_req r, input bit typed, input t_led_report want);
        int          gap;
        t_led_report rep;
        gap = idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, r.total, r.off_t, r.on_t, r.level};
        i_s_tuser  <= r.cmd;
        do @(posedge i_clk); while (!o_s_tready);
        rep = advance_led(r);
        req_cnt++;
        if (r.cmd == CMD_START) begin
            if (rep.status == STS_REJECTED) reject_cnt++;
            else start_cnt++;
        end
        pending_reports.push_back(typed ? want : rep);
    endtask

    function automatic t_led_req random_req();
        t_led_req r;
        int       pick;
        r.cmd   = CMD_TICK;
        r.level = 1'($urandom);
        r.on_t  = 16'($urandom);
        r.off_t = 16'($urandom);
        r.total = 16'($urandom);
        pick    = $urandom_range(0, 99);
        if (pick < 8) begin
            r.cmd = CMD_SET;
        end else if (pick < 14) begin
            r.cmd = CMD_TOGGLE;
        end else if (pick < 30) begin
            r.cmd = CMD_START;
            r.on_t  = 16'($urandom_range(1, 6));
            r.off_t = 16'($urandom_range(1, 6));
            r.total = 16'($urandom_range(0, 4));
        end else if (pick < 33) begin
            // full-range start; zero times fall through to the reject path
            r.cmd = CMD_START;
        end else if (pick < 36) begin
            r.cmd = CMD_START;
            case ($urandom_range(0, 2))
                0: r.on_t = '0;
                1: r.off_t = '0;
                default: begin
                    r.on_t  = '0;
                    r.off_t = '0;
                end
            endcase
        end
        return r;
    endfunction

    task automatic check_report(input logic [OUT_DATA_BITS-1:0] d);
        t_led_report want;
        if (pending_reports.size() == 0) begin
            $error("result with no request pending: tdata %h", d);
            mismatch_cnt++;
            return;
        end
        want = pending_reports.pop_front();
        if (d[0] !== want.led) begin
            $error("led_level: expected %0d, got %0d", want.led, d[0]);
            mismatch_cnt++;
        end
        if (d[1] !== want.blinking) begin
            $error("blinking: expected %0d, got %0d", want.blinking, d[1]);
            mismatch_cnt++;
        end
        if (d[17:2] !== want.done) begin
            $error("blinks_done: expected %0d, got %0d", want.done, d[17:2]);
            mismatch_cnt++;
        end
        if (d[18] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, d[18]);
            mismatch_cnt++;
        end
    endtask

    initial begin
        int stall;
        i_m_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = idle_on ? $urandom_range(0, 16) : 0;
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            check_report(o_m_tdata);
        end
    end

    initial begin
        t_led_report none;
        none = '{1'b0, 1'b0, 16'd0, STS_OK};
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= CMD_TICK;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_on = 1'b1;
        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

        // run a burst of ticks on the endless sequence, back to back
        idle_on = 1'b0;
        repeat (BURST_TICKS)
            send_req('{CMD_TICK, 1'b0, 16'd0, 16'd0, 16'd0}, 1'b0, none);

        for (int blk = 0; blk < RAND_ITEMS / 50; blk++) begin
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (50) send_req(random_req(), 1'b0, none);
        end
        i_s_tvalid <= 1'b0;

        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d requests: %0d blink starts, %0d rejected starts.",
                 req_cnt, start_cnt, reject_cnt);
        $display("Included a back-to-back tick burst and random idle and stall cycles.");
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #(400_000 * 10);
        $display("Mismatches found");
        $finish;
    end

endmodule
